FILE: hw/rtl/swam_pkg.sv
// Package for the sliding window anagram matcher.
// Holds sizing constants, item kind codes and controller state codes.
// No dependencies.
`default_nettype none

package swam_pkg;

  // Largest pattern, in bytes, that one job can hold
  localparam int unsigned SWAM_MAX_PATTERN = 1024;

  // Count table: one entry per byte value
  localparam int unsigned SWAM_CNT_DEPTH = 256;
  localparam int unsigned SWAM_SYM_W     = 8;
  // Nonzero entry tally, holds 0..SWAM_CNT_DEPTH
  localparam int unsigned SWAM_TALLY_W   = 9;

  // Item kind, carried in tuser
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_TEXT    = 2'd2
  } swam_action_e;

  // Controller states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAT  = 5'b00010,
    ST_TIN  = 5'b00100,
    ST_TOUT = 5'b01000,
    ST_EMIT = 5'b10000
  } swam_state_e;

endpackage

`default_nettype wire

FILE: hw/rtl/sliding_window_anagram_match.sv
// Sliding window anagram matcher: count table and delay line in synchronous RAMs.
// Depends on swam_pkg.
// Input is taken only in idle. A clear is done there; a pattern byte reads its
// count RAM entry, then writes it back; a text byte does the same on its own
// entry, and once the window is full the outgoing byte does a read-modify-write
// on the single-port-write count RAM. Text under overflow or with an empty
// pattern goes straight to the emit state. The result lands in an output register.
// Reset: rst_ni clears all control state and count valid bits at once; no sweep.
`default_nettype none

module sliding_window_anagram_match
  import swam_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = SWAM_MAX_PATTERN
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // input stream
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  wire logic [1:0] s_axis_tuser_i,   // [1:0] action
  // result stream
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o    // [0] matched_now, [1] found,
                                            // [2] overflow, [7:3] zero
);

  // count entries span -MAX_PATTERN..MAX_PATTERN
  localparam int unsigned CW  = $clog2(MAX_PATTERN + 1) + 1;
  // pattern size / text seen counters, 0..MAX_PATTERN
  localparam int unsigned PSW = $clog2(MAX_PATTERN + 1);
  // delay line index
  localparam int unsigned PW  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int unsigned TW  = SWAM_TALLY_W;
  localparam int unsigned AW  = $clog2(SWAM_CNT_DEPTH);

  // ---------------------------------------------------------------------
  // Storage
  // ---------------------------------------------------------------------
  logic [CW-1:0]         cnt_mem [SWAM_CNT_DEPTH];
  logic [SWAM_SYM_W-1:0] win_mem [MAX_PATTERN];

  // count RAM ports
  logic          cnt_re, cnt_we;
  logic [AW-1:0] cnt_raddr, cnt_waddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata_q;
  logic          cnt_rvalid_q;
  // entries never written since the last clear read as zero
  logic [SWAM_CNT_DEPTH-1:0] cnt_valid_q;

  // delay line RAM port (read-first on the shared address)
  logic                  win_en, win_we;
  logic [PW-1:0]         win_addr;
  logic [SWAM_SYM_W-1:0] win_rdata_q;

  // ---------------------------------------------------------------------
  // Job state
  // ---------------------------------------------------------------------
  swam_state_e           state_q, state_d;
  logic [TW-1:0]         tally_q, tally_d;
  logic [PSW-1:0]        psize_q, psize_d;
  logic [PSW-1:0]        seen_q, seen_d;
  logic [PW-1:0]         ptr_q, ptr_d;
  logic                  found_q, found_d;
  logic                  ovf_q, ovf_d;
  logic                  started_q, started_d;
  logic                  full_q, full_d;       // window was full when byte came in
  logic [SWAM_SYM_W-1:0] sym_q, sym_d;
  logic                  res_match_q, res_match_d;
  // same-entry forwarding: outgoing byte equals incoming byte
  logic                  fwd_hit_q, fwd_hit_d;
  logic [CW-1:0]         fwd_val_q, fwd_val_d;

  // output register
  logic       m_valid_q, m_valid_d;
  logic [2:0] m_data_q, m_data_d;

  // ---------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------
  logic          in_xfer;
  logic          out_space;
  logic [CW-1:0] cnt_before;
  logic [PW-1:0] ptr_sel;
  logic [PSW:0]  ptr_inc;
  logic          emit;
  logic          emit_match;
  swam_action_e  action;

  assign action     = swam_action_e'(s_axis_tuser_i);
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_space  = !m_valid_q || m_axis_tready_i;
  assign cnt_before = cnt_rvalid_q ? cnt_rdata_q : '0;

  // slot for this byte; guard against a stale pointer
  assign ptr_sel = (PSW'(ptr_q) >= psize_q) ? '0 : ptr_q;
  assign ptr_inc = (PSW + 1)'(ptr_sel) + (PSW + 1)'(1);

  always_comb begin
    state_d     = state_q;
    tally_d     = tally_q;
    psize_d     = psize_q;
    seen_d      = seen_q;
    ptr_d       = ptr_q;
    found_d     = found_q;
    ovf_d       = ovf_q;
    started_d   = started_q;
    full_d      = full_q;
    sym_d       = sym_q;
    res_match_d = res_match_q;
    fwd_hit_d   = fwd_hit_q;
    fwd_val_d   = fwd_val_q;

    cnt_re    = 1'b0;
    cnt_raddr = s_axis_tdata_i;
    cnt_we    = 1'b0;
    cnt_waddr = sym_q;
    cnt_wdata = cnt_before;
    win_en    = 1'b0;
    win_we    = 1'b0;
    win_addr  = ptr_sel;

    emit       = 1'b0;
    emit_match = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          sym_d = s_axis_tdata_i;
          case (action)
            ACT_CLEAR: begin
              tally_d   = '0;
              psize_d   = '0;
              seen_d    = '0;
              ptr_d     = '0;
              found_d   = 1'b0;
              ovf_d     = 1'b0;
              started_d = 1'b0;
            end
            ACT_PATTERN: begin
              if (!started_q) begin
                if (psize_q == PSW'(MAX_PATTERN)) begin
                  ovf_d = 1'b1;
                end else begin
                  cnt_re  = 1'b1;
                  state_d = ST_PAT;
                end
              end
            end
            ACT_TEXT: begin
              started_d = 1'b1;
              if (ovf_q || (psize_q == '0)) begin
                // forced result: overflow never matches, empty pattern always does
                res_match_d = !ovf_q;
                state_d     = ST_EMIT;
              end else begin
                cnt_re   = 1'b1;
                win_en   = 1'b1;
                win_we   = 1'b1;
                full_d   = (seen_q >= psize_q);
                if (seen_q < psize_q) seen_d = seen_q + PSW'(1);
                ptr_d    = (ptr_inc >= (PSW + 1)'(psize_q)) ? '0 : PW'(ptr_inc);
                state_d  = ST_TIN;
              end
            end
            default: ;  // unused code: dropped
          endcase
        end
      end

      ST_PAT: begin
        // pattern byte lowers its count
        cnt_we    = 1'b1;
        cnt_wdata = cnt_before - CW'(1);
        if (cnt_before == '0)             tally_d = tally_q + TW'(1);
        else if (cnt_before == CW'(1))    tally_d = tally_q - TW'(1);
        psize_d = psize_q + PSW'(1);
        state_d = ST_IDLE;
      end

      ST_TIN: begin
        // incoming text byte raises its count
        cnt_we    = 1'b1;
        cnt_wdata = cnt_before + CW'(1);
        if (cnt_before == '0)             tally_d = tally_q + TW'(1);
        else if (cnt_before == '1)        tally_d = tally_q - TW'(1);
        fwd_hit_d = (win_rdata_q == sym_q);
        fwd_val_d = cnt_before + CW'(1);
        if (full_q) begin
          cnt_re    = 1'b1;
          cnt_raddr = win_rdata_q;
          sym_d     = win_rdata_q;
          state_d   = ST_TOUT;
        end else begin
          emit_match = (seen_q >= psize_q) && (tally_d == '0);
          emit       = 1'b1;
        end
      end

      ST_TOUT: begin
        // oldest byte leaves the window; same entry as the write just done
        // comes from the forwarding register
        cnt_wdata = (fwd_hit_q ? fwd_val_q : cnt_before) - CW'(1);
        cnt_we    = 1'b1;
        if ((fwd_hit_q ? fwd_val_q : cnt_before) == '0)
          tally_d = tally_q + TW'(1);
        else if ((fwd_hit_q ? fwd_val_q : cnt_before) == CW'(1))
          tally_d = tally_q - TW'(1);
        emit_match = (tally_d == '0);
        emit       = 1'b1;
      end

      ST_EMIT: begin
        emit_match = res_match_q;
        emit       = 1'b1;
      end

      default: state_d = ST_IDLE;
    endcase

    // hand the result to the output register, or park it until there is room
    if (emit) begin
      if (out_space) begin
        found_d = found_q | emit_match;
        state_d = ST_IDLE;
      end else begin
        res_match_d = emit_match;
        state_d     = ST_EMIT;
      end
    end
  end

  always_comb begin
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    if (emit && out_space) begin
      m_valid_d = 1'b1;
      m_data_d  = {ovf_q, found_q | emit_match, emit_match};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'b0, m_data_q};

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tally_q     <= '0;
      psize_q     <= '0;
      seen_q      <= '0;
      ptr_q       <= '0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      started_q   <= 1'b0;
      full_q      <= 1'b0;
      res_match_q <= 1'b0;
      fwd_hit_q   <= 1'b0;
      m_valid_q   <= 1'b0;
      cnt_valid_q <= '0;
    end else begin
      state_q     <= state_d;
      tally_q     <= tally_d;
      psize_q     <= psize_d;
      seen_q      <= seen_d;
      ptr_q       <= ptr_d;
      found_q     <= found_d;
      ovf_q       <= ovf_d;
      started_q   <= started_d;
      full_q      <= full_d;
      res_match_q <= res_match_d;
      fwd_hit_q   <= fwd_hit_d;
      m_valid_q   <= m_valid_d;
      if (in_xfer && (action == ACT_CLEAR)) begin
        cnt_valid_q <= '0;
      end else if (cnt_we) begin
        cnt_valid_q[cnt_waddr] <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    fwd_val_q <= fwd_val_d;
    m_data_q  <= m_data_d;
  end

  // count table RAM, registered read
  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (cnt_re) begin
      cnt_rdata_q  <= cnt_mem[cnt_raddr];
      cnt_rvalid_q <= cnt_valid_q[cnt_raddr];
    end
  end

  // delay line RAM, read-first
  always_ff @(posedge clk_i) begin
    if (win_en) begin
      if (win_we) win_mem[win_addr] <= sym_d;
      win_rdata_q <= win_mem[win_addr];
    end
  end

endmodule

`default_nettype wire
